// File: hw/rtl/bblur_pkg.sv
// Shared types and constants for the 3x3 box blur stream block.
// Used by the controller, the datapath and the top level; no dependencies.
`timescale 1ns / 1ps

package bblur_pkg;

    localparam int CH_W       = 8;
    localparam int NUM_CH     = 3;
    localparam int PIX_W      = CH_W * NUM_CH;
    localparam int CFG_W_W    = 11;
    localparam int CFG_H_W    = 13;
    localparam int CFG_DATA_W = 13;
    localparam int CFG_IDX_W  = 1;
    localparam int SUM_W      = 12;
    localparam int CNT_W      = 4;
    localparam int NUM_W      = 13;
    localparam int DEN_W      = 5;
    localparam int DIV_STEPS  = 8;
    localparam int STEP_W     = 3;

    localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 1'b1;

    localparam logic [CFG_W_W-1:0] FRAME_WIDTH_RST  = 11'd1024;
    localparam logic [CFG_H_W-1:0] FRAME_HEIGHT_RST = 13'd1024;

    typedef logic [PIX_W-1:0] t_pix;

    typedef struct packed {
        logic take;
        logic shift;
        logic sum;
        logic div_init;
        logic div_step;
        logic load;
    } t_cmd;

    typedef struct packed {
        logic emit;
        logic out_free;
    } t_status;

endpackage

// File: hw/rtl/bblur_ctrl.sv
// Sequencer for the box blur: accept, window shift, sum, divide, output load.
// Depends on bblur_pkg.
`timescale 1ns / 1ps

module bblur_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  bblur_pkg::t_status i_status,
    output bblur_pkg::t_cmd    o_cmd
);
    import bblur_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SHIFT,
        ST_SUM,
        ST_INIT,
        ST_DIV,
        ST_LOAD
    } t_state;

    t_state            r_state, n_state;
    logic [STEP_W-1:0] r_step, n_step;

    always_comb begin
        n_state = r_state;
        n_step  = r_step;
        o_cmd   = '0;
        case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.take = 1'b1;
                    n_state    = ST_SHIFT;
                end
            end
            ST_SHIFT: begin
                o_cmd.shift = 1'b1;
                n_state     = i_status.emit ? ST_SUM : ST_IDLE;
            end
            ST_SUM: begin
                o_cmd.sum = 1'b1;
                n_state   = ST_INIT;
            end
            ST_INIT: begin
                o_cmd.div_init = 1'b1;
                n_step         = '0;
                n_state        = ST_DIV;
            end
            ST_DIV: begin
                o_cmd.div_step = 1'b1;
                n_step         = r_step + 1'b1;
                if (r_step == STEP_W'(DIV_STEPS - 1)) begin
                    n_state = ST_LOAD;
                end
            end
            ST_LOAD: begin
                if (i_status.out_free) begin
                    o_cmd.load = 1'b1;
                    n_state    = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    assign o_in_stall = (r_state != ST_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_step  <= '0;
        end else begin
            r_state <= n_state;
            r_step  <= n_step;
        end
    end

endmodule

// File: hw/rtl/bblur_dp.sv
// Box blur datapath: frame registers, position counters, two line memories,
// 3x3 window, masked sums, shift-subtract dividers and the output register.
// Depends on bblur_pkg.
`timescale 1ns / 1ps

module bblur_dp #(
    parameter int MAX_WIDTH = 1024,
    parameter int MAX_ROWS  = 4096
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [bblur_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [bblur_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  logic [bblur_pkg::CH_W-1:0]       i_in_red,
    input  logic [bblur_pkg::CH_W-1:0]       i_in_green,
    input  logic [bblur_pkg::CH_W-1:0]       i_in_blue,
    input  logic                           i_drain,
    input  bblur_pkg::t_cmd                  i_cmd,
    output bblur_pkg::t_status               o_status,
    input  logic                           i_out_stall,
    output logic                           o_out_valid,
    output logic [bblur_pkg::CH_W-1:0]       o_out_red,
    output logic [bblur_pkg::CH_W-1:0]       o_out_green,
    output logic [bblur_pkg::CH_W-1:0]       o_out_blue,
    output logic                           o_frame_last
);
    import bblur_pkg::*;

    localparam int COL_W = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int ROW_W = $clog2(MAX_ROWS + 2);
    localparam int XW    = (COL_W + 1 > CFG_W_W) ? COL_W + 1 : CFG_W_W;
    localparam int YW    = (ROW_W + 1 > CFG_H_W) ? ROW_W + 1 : CFG_H_W;
    localparam int W_CAP = (MAX_WIDTH > 2047) ? 2047 : MAX_WIDTH;
    localparam int H_CAP = (MAX_ROWS > 8191) ? 8191 : MAX_ROWS;

    function automatic logic [CFG_W_W-1:0] sat_w(input logic [CFG_W_W-1:0] v);
        logic [CFG_W_W-1:0] res;
        res = v;
        if (v == '0) res = CFG_W_W'(1);
        else if (v > CFG_W_W'(W_CAP)) res = CFG_W_W'(W_CAP);
        return res;
    endfunction

    function automatic logic [CFG_H_W-1:0] sat_h(input logic [CFG_H_W-1:0] v);
        logic [CFG_H_W-1:0] res;
        res = v;
        if (v == '0) res = CFG_H_W'(1);
        else if (v > CFG_H_W'(H_CAP)) res = CFG_H_W'(H_CAP);
        return res;
    endfunction

    logic [CFG_W_W-1:0] r_w;
    logic [CFG_H_W-1:0] r_h;
    logic [COL_W-1:0]   r_col;
    logic [ROW_W-1:0]   r_row;

    t_pix r_mem_up  [MAX_WIDTH];
    t_pix r_mem_mid [MAX_WIDTH];
    t_pix r_pix, r_top, r_mid;
    t_pix r_win [3][3];

    logic [8:0]       r_mask;
    logic             r_last;
    logic [SUM_W-1:0] r_sum [NUM_CH];
    logic [CNT_W-1:0] r_cnt;
    logic [DEN_W-1:0] r_den;
    logic [DEN_W-1:0] r_rem [NUM_CH];
    logic [CH_W-1:0]  r_num [NUM_CH];
    logic [CH_W-1:0]  r_quo [NUM_CH];
    logic             r_out_valid;
    logic [CH_W-1:0]  r_out_ch [NUM_CH];
    logic             r_out_last;

    // Output position of the window center
    logic          emit_raw, emit, last;
    logic [YW-1:0] orow;
    logic [XW-1:0] ocol;
    logic [XW-1:0] col_inc;
    logic [2:0]    rv, cv;
    logic [8:0]    mask;

    always_comb begin
        emit_raw = 1'b0;
        orow     = '0;
        ocol     = '0;
        if (r_col != '0) begin
            emit_raw = (r_row != '0);
            orow     = YW'(r_row) - YW'(1);
            ocol     = XW'(r_col) - XW'(1);
        end else begin
            emit_raw = (r_row >= ROW_W'(2));
            orow     = YW'(r_row) - YW'(2);
            ocol     = XW'(r_w) - XW'(1);
        end
        emit = emit_raw && (orow < YW'(r_h));
        rv   = {(orow + YW'(1)) < YW'(r_h), 1'b1, orow != '0};
        cv   = {(ocol + XW'(1)) < XW'(r_w), 1'b1, ocol != '0};
        for (int r = 0; r < 3; r++) begin
            for (int c = 0; c < 3; c++) begin
                mask[r*3+c] = rv[r] && cv[c];
            end
        end
        last    = (orow + YW'(1) == YW'(r_h)) && (ocol + XW'(1) == XW'(r_w));
        col_inc = XW'(r_col) + XW'(1);
    end

    assign o_status.emit     = emit;
    assign o_status.out_free = !r_out_valid || !i_out_stall;

    // Config, counters and output handshake
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_w         <= sat_w(FRAME_WIDTH_RST);
            r_h         <= sat_h(FRAME_HEIGHT_RST);
            r_col       <= '0;
            r_row       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    REG_FRAME_WIDTH:  r_w <= sat_w(i_cfg_data[CFG_W_W-1:0]);
                    REG_FRAME_HEIGHT: r_h <= sat_h(i_cfg_data[CFG_H_W-1:0]);
                    default: ;
                endcase
                r_col <= '0;
                r_row <= '0;
            end else if (i_cmd.shift) begin
                if (emit && last) begin
                    r_col <= '0;
                    r_row <= '0;
                end else if (col_inc >= XW'(r_w)) begin
                    r_col <= '0;
                    r_row <= r_row + 1'b1;
                end else begin
                    r_col <= col_inc[COL_W-1:0];
                end
            end
            if (i_cmd.load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Line memories: read on accept, write back on shift
    always_ff @(posedge i_clk) begin
        if (i_cmd.take) begin
            r_top <= r_mem_up[r_col];
            r_mid <= r_mem_mid[r_col];
        end
        if (i_cmd.shift) begin
            r_mem_up[r_col]  <= r_mid;
            r_mem_mid[r_col] <= r_pix;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int r = 0; r < 3; r++) begin
                for (int c = 0; c < 3; c++) begin
                    r_win[r][c] <= '0;
                end
            end
        end else if (i_cmd.shift) begin
            for (int r = 0; r < 3; r++) begin
                r_win[r][0] <= r_win[r][1];
                r_win[r][1] <= r_win[r][2];
            end
            r_win[0][2] <= r_top;
            r_win[1][2] <= r_mid;
            r_win[2][2] <= r_pix;
        end
    end

    // Masked sums
    logic [SUM_W-1:0] sum_c [NUM_CH];

    always_comb begin
        for (int k = 0; k < NUM_CH; k++) begin
            sum_c[k] = '0;
            for (int r = 0; r < 3; r++) begin
                for (int c = 0; c < 3; c++) begin
                    if (r_mask[r*3+c]) begin
                        sum_c[k] = sum_c[k]
                                 + SUM_W'(r_win[r][c][(NUM_CH-1-k)*CH_W +: CH_W]);
                    end
                end
            end
        end
    end

    // Round half up: q = (2*sum + cnt) / (2*cnt), one quotient bit per step
    logic [NUM_W-1:0] numer [NUM_CH];
    logic [DEN_W:0]   trial [NUM_CH];
    logic [DEN_W:0]   diff  [NUM_CH];

    always_comb begin
        for (int k = 0; k < NUM_CH; k++) begin
            numer[k] = {r_sum[k], 1'b0} + NUM_W'(r_cnt);
            trial[k] = {r_rem[k], r_num[k][CH_W-1]};
            diff[k]  = trial[k] - {1'b0, r_den};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.take) begin
            r_pix <= i_drain ? '0 : {i_in_red, i_in_green, i_in_blue};
        end
        if (i_cmd.shift) begin
            r_mask <= mask;
            r_last <= last;
        end
        if (i_cmd.sum) begin
            r_cnt <= CNT_W'($countones(r_mask));
            for (int k = 0; k < NUM_CH; k++) begin
                r_sum[k] <= sum_c[k];
            end
        end
        if (i_cmd.div_init) begin
            r_den <= {r_cnt, 1'b0};
            for (int k = 0; k < NUM_CH; k++) begin
                r_rem[k] <= numer[k][NUM_W-1:CH_W];
                r_num[k] <= numer[k][CH_W-1:0];
            end
        end
        if (i_cmd.div_step) begin
            for (int k = 0; k < NUM_CH; k++) begin
                if (trial[k] >= {1'b0, r_den}) begin
                    r_rem[k] <= diff[k][DEN_W-1:0];
                    r_quo[k] <= {r_quo[k][CH_W-2:0], 1'b1};
                end else begin
                    r_rem[k] <= trial[k][DEN_W-1:0];
                    r_quo[k] <= {r_quo[k][CH_W-2:0], 1'b0};
                end
                r_num[k] <= {r_num[k][CH_W-2:0], 1'b0};
            end
        end
        if (i_cmd.load) begin
            for (int k = 0; k < NUM_CH; k++) begin
                r_out_ch[k] <= r_quo[k];
            end
            r_out_last <= r_last;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_out_red    = r_out_ch[0];
    assign o_out_green  = r_out_ch[1];
    assign o_out_blue   = r_out_ch[2];
    assign o_frame_last = r_out_last;

endmodule

// File: hw/rtl/box_blur_3x3_stream_top.sv
// Top level of the 3x3 box blur stream block: controller plus datapath.
// Depends on bblur_pkg, bblur_ctrl and bblur_dp.
`timescale 1ns / 1ps

// RGB pixels enter in raster order; each result is the per-channel average
// of the in-frame 3x3 neighbours, rounded half up. The result for a position
// leaves frame_width+1 items after that position enters, so send frame_width+1
// drain items after a frame's last pixel. One item is taken at a time; it is
// shifted into the window and, if it yields a result, summed, divided by the
// channels' 8-step shift-subtract dividers in parallel and loaded out, waiting
// on a stalled output. A finished result sits in the output register while
// the next item is taken; frame_last marks the frame's final result. Register
// writes restart the frame; the user must make them while idle (unenforced).

module box_blur_3x3_stream_top #(
    parameter int MAX_WIDTH = 1024,
    parameter int MAX_ROWS  = 4096
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [bblur_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [bblur_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  logic                           i_in_valid,
    output logic                           o_in_stall,
    input  logic [bblur_pkg::CH_W-1:0]       i_in_red,
    input  logic [bblur_pkg::CH_W-1:0]       i_in_green,
    input  logic [bblur_pkg::CH_W-1:0]       i_in_blue,
    input  logic                           i_drain,
    output logic                           o_out_valid,
    input  logic                           i_out_stall,
    output logic [bblur_pkg::CH_W-1:0]       o_out_red,
    output logic [bblur_pkg::CH_W-1:0]       o_out_green,
    output logic [bblur_pkg::CH_W-1:0]       o_out_blue,
    output logic                           o_frame_last
);
    import bblur_pkg::*;

    t_cmd    cmd;
    t_status status;

    bblur_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    bblur_dp #(
        .MAX_WIDTH (MAX_WIDTH),
        .MAX_ROWS  (MAX_ROWS)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .i_in_red     (i_in_red),
        .i_in_green   (i_in_green),
        .i_in_blue    (i_in_blue),
        .i_drain      (i_drain),
        .i_cmd        (cmd),
        .o_status     (status),
        .i_out_stall  (i_out_stall),
        .o_out_valid  (o_out_valid),
        .o_out_red    (o_out_red),
        .o_out_green  (o_out_green),
        .o_out_blue   (o_out_blue),
        .o_frame_last (o_frame_last)
    );

    a_take_then_shift: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.take |=> cmd.shift)
        else $error("window shift did not follow an accepted item");

    a_init_then_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.div_init |=> cmd.div_step)
        else $error("divider init not followed by a step");

    a_load_only_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.load |-> status.out_free)
        else $error("output loaded over an untaken item");

    a_valid_from_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(cmd.load))
        else $error("output valid rose without a load");

endmodule
